// File: rtl/atw_pkg.sv
// ----------------------------------------------------------------------------
// atw_pkg: shared types and constants of the arrival time window calculator
// Request payloads, lane records of the root and divide chains, register codes.
// ----------------------------------------------------------------------------
package atw_pkg;

	localparam int SQ_STEPS = 27;   // root bits of a 54-bit radicand
	localparam int DV_STEPS = 24;   // quotient bits kept before saturation

	localparam logic signed [23:0] TIME_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] TIME_MIN = 24'sh800000;

	typedef enum logic [1:0] {
		REG_TOP_SPEED   = 2'd0,
		REG_FLOOR_SPEED = 2'd1,
		REG_ACCEL_LIMIT = 2'd2
	} atw_reg_t;

	typedef struct packed {
		logic [15:0] speed_now;
		logic [19:0] distance_left;
	} atw_in_t;

	typedef struct packed {
		logic signed [23:0] earliest_arrival;
		logic signed [23:0] latest_arrival;
	} atw_out_t;

	typedef struct packed {
		logic [53:0] x;
		logic [28:0] rem;
		logic [26:0] root;
	} atw_sq_lane_t;

	typedef struct packed {
		logic               e_root;
		logic               l_root;
		logic               vf_zero;
		logic [44:0]        e_cnum;
		logic signed [45:0] l_cnum;
		logic [27:0]        e_den;
		logic [27:0]        l_den;
		logic [11:0]        a;
		logic [23:0]        v256;
	} atw_side_t;

	typedef struct packed {
		atw_sq_lane_t e;
		atw_sq_lane_t l;
		atw_side_t    side;
	} atw_sq_t;

	typedef struct packed {
		logic [44:0] r;
		logic [50:0] dsh;
		logic [23:0] q;
		logic        neg;
		logic        ovf;
		logic        never;
	} atw_dv_lane_t;

	typedef struct packed {
		atw_dv_lane_t e;
		atw_dv_lane_t l;
	} atw_dv_t;

endpackage

// File: rtl/atw_sqrt_cell.sv
// ----------------------------------------------------------------------------
// atw_sqrt_cell: one digit step of the square root chain
// Retires one root bit in each lane and passes the record to the next cell.
// ----------------------------------------------------------------------------
module atw_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            in_valid,
	input  atw_pkg::atw_sq_t in_data,
	output logic            out_valid,
	output atw_pkg::atw_sq_t out_data
);
	import atw_pkg::*;

	logic    valid_q;
	atw_sq_t data_q;
	atw_sq_t nxt;

	function automatic atw_sq_lane_t step(input atw_sq_lane_t ln);
		atw_sq_lane_t o;
		logic [30:0]  rem_w;
		logic [30:0]  trial;
		rem_w = {ln.rem, ln.x[53:52]};
		trial = {2'b00, ln.root, 2'b01};
		o.x = {ln.x[51:0], 2'b00};
		if (rem_w >= trial) begin
			o.rem  = 29'(rem_w - trial);
			o.root = {ln.root[25:0], 1'b1};
		end else begin
			o.rem  = rem_w[28:0];
			o.root = {ln.root[25:0], 1'b0};
		end
		return o;
	endfunction

	always_comb begin
		nxt      = in_data;
		nxt.e    = step(in_data.e);
		nxt.l    = step(in_data.l);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// File: rtl/atw_div_cell.sv
// ----------------------------------------------------------------------------
// atw_div_cell: one restoring step of the divide chain
// Retires one quotient bit in each lane and passes the record on.
// ----------------------------------------------------------------------------
module atw_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            in_valid,
	input  atw_pkg::atw_dv_t in_data,
	output logic            out_valid,
	output atw_pkg::atw_dv_t out_data
);
	import atw_pkg::*;

	logic    valid_q;
	atw_dv_t data_q;
	atw_dv_t nxt;

	function automatic atw_dv_lane_t step(input atw_dv_lane_t ln);
		atw_dv_lane_t o;
		o     = ln;
		o.dsh = {1'b0, ln.dsh[50:1]};
		if ({6'b0, ln.r} >= ln.dsh) begin
			o.r = ln.r - ln.dsh[44:0];
			o.q = {ln.q[22:0], 1'b1};
		end else begin
			o.q = {ln.q[22:0], 1'b0};
		end
		return o;
	endfunction

	always_comb begin
		nxt.e = step(in_data.e);
		nxt.l = step(in_data.l);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// File: rtl/arrival_time_window_calc.sv
// ----------------------------------------------------------------------------
// arrival_time_window_calc: earliest and latest arrival time at the stop line
// Pipelined root and divide chains, one vehicle request per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        in         in_valid / in_stall  in_data  (speed_now, distance_left)
//  out       out        out_valid/ out_stall out_data (earliest, latest arrival)
//  cfg       in         cfg_we               cfg_idx, cfg_wdata
//
//  The pipe holds two front stages, 27 root cells, two divide setup stages,
//  24 divide cells and the output register. One request per cycle while
//  in_stall is low. Every stage moves when it is empty or its successor
//  moves, so bubbles collapse and requests keep entering while a result
//  waits at the output. Reset clears the valid bits, loads register defaults.
// ----------------------------------------------------------------------------
module arrival_time_window_calc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  atw_pkg::atw_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output atw_pkg::atw_out_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [15:0]       cfg_wdata
);
	import atw_pkg::*;

	// configuration registers
	logic [15:0] top_speed_q, floor_speed_q;
	logic [11:0] accel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_speed_q   <= 16'd4096;
			floor_speed_q <= 16'd1792;
			accel_q       <= 12'd256;
		end else if (cfg_we) begin
			case (atw_reg_t'(cfg_idx))
				REG_TOP_SPEED:   top_speed_q   <= cfg_wdata;
				REG_FLOOR_SPEED: floor_speed_q <= cfg_wdata;
				REG_ACCEL_LIMIT: accel_q       <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	// ready chain, back to front
	logic                 rdy_out, rdy_s4, rdy_s3, rdy_s2, rdy_s1;
	logic [SQ_STEPS-1:0]  sq_vld, sq_rdy;
	logic [DV_STEPS-1:0]  dv_vld, dv_rdy;
	atw_sq_t              sq_data [SQ_STEPS];
	atw_dv_t              dv_data [DV_STEPS];
	logic                 vld_s1, vld_s2, vld_s3, vld_s4;

	assign rdy_out  = !out_valid || !out_stall;
	assign rdy_s4   = !vld_s4 || dv_rdy[0];
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || sq_rdy[0];
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// stage 1: products
	logic [11:0] a_eff;
	logic [15:0] vm_eff, dve, dvl;
	logic [15:0] v_s1;
	logic [31:0] v2_s1, ad_s1, vm2_s1, vf2_s1, dve2_s1, dvl2_s1;
	logic [27:0] eden_s1, lden_s1;
	logic [11:0] a_s1;
	logic        vfz_s1;

	assign a_eff  = (accel_q == 12'd0) ? 12'd1 : accel_q;
	assign vm_eff = (top_speed_q == 16'd0) ? 16'd1 : top_speed_q;
	assign dve    = (in_data.speed_now >= vm_eff) ? in_data.speed_now - vm_eff
	                                              : vm_eff - in_data.speed_now;
	assign dvl    = (in_data.speed_now >= floor_speed_q) ? in_data.speed_now - floor_speed_q
	                                                     : floor_speed_q - in_data.speed_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			v_s1    <= in_data.speed_now;
			v2_s1   <= in_data.speed_now * in_data.speed_now;
			ad_s1   <= 32'(a_eff * in_data.distance_left);
			vm2_s1  <= vm_eff * vm_eff;
			vf2_s1  <= floor_speed_q * floor_speed_q;
			dve2_s1 <= dve * dve;
			dvl2_s1 <= dvl * dvl;
			eden_s1 <= 28'(a_eff * vm_eff);
			lden_s1 <= 28'(a_eff * floor_speed_q);
			a_s1    <= a_eff;
			vfz_s1  <= (floor_speed_q == 16'd0);
		end
	end

	// stage 2: case selection, radicands, cruise numerators
	logic [36:0]        k2;
	logic [37:0]        sum_e, sum_l, cn_e;
	logic [31:0]        diff_l;
	logic signed [38:0] lc;
	atw_sq_t            sq_nxt, sq_in_s2;

	always_comb begin
		k2     = {ad_s1, 5'b0};
		sum_e  = {6'b0, v2_s1} + {1'b0, k2};
		sum_l  = {6'b0, vf2_s1} + {1'b0, k2};
		cn_e   = {1'b0, k2} + {6'b0, dve2_s1};
		diff_l = 32'({6'b0, v2_s1} - {1'b0, k2});
		lc     = $signed({2'b0, k2}) - $signed({7'b0, dvl2_s1});

		sq_nxt.side.e_root  = ({6'b0, vm2_s1} >= sum_e);
		sq_nxt.side.l_root  = ({6'b0, v2_s1} >= sum_l);
		sq_nxt.side.vf_zero = vfz_s1;
		sq_nxt.side.e_cnum  = {cn_e, 7'b0};
		sq_nxt.side.l_cnum  = {lc, 7'b0};
		sq_nxt.side.e_den   = eden_s1;
		sq_nxt.side.l_den   = lden_s1;
		sq_nxt.side.a       = a_s1;
		sq_nxt.side.v256    = {v_s1, 8'b0};

		sq_nxt.e.x    = {sum_e, 16'b0};
		sq_nxt.e.rem  = '0;
		sq_nxt.e.root = '0;
		sq_nxt.l.x    = sq_nxt.side.l_root ? {6'b0, diff_l, 16'b0} : 54'd0;
		sq_nxt.l.rem  = '0;
		sq_nxt.l.root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			sq_in_s2 <= sq_nxt;
		end
	end

	// square root chain
	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		if (i == SQ_STEPS - 1) begin : g_last
			assign sq_rdy[i] = !sq_vld[i] || rdy_s3;
		end else begin : g_mid
			assign sq_rdy[i] = !sq_vld[i] || sq_rdy[i+1];
		end
		if (i == 0) begin : g_first
			atw_sqrt_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.advance  (sq_rdy[i]),
				.in_valid (vld_s2),
				.in_data  (sq_in_s2),
				.out_valid(sq_vld[i]),
				.out_data (sq_data[i])
			);
		end else begin : g_next
			atw_sqrt_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.advance  (sq_rdy[i]),
				.in_valid (sq_vld[i-1]),
				.in_data  (sq_data[i-1]),
				.out_valid(sq_vld[i]),
				.out_data (sq_data[i])
			);
		end
	end

	// stage 3: divide operands
	atw_sq_t sq_last;
	atw_dv_t d3_nxt, d3_s3;
	logic    l_neg;

	always_comb begin
		sq_last = sq_data[SQ_STEPS-1];
		l_neg   = sq_last.side.l_cnum[45];

		d3_nxt.e.q     = '0;
		d3_nxt.e.ovf   = 1'b0;
		d3_nxt.e.neg   = 1'b0;
		d3_nxt.e.never = 1'b0;
		if (sq_last.side.e_root) begin
			d3_nxt.e.r   = {18'b0, sq_last.e.root - {3'b0, sq_last.side.v256}};
			d3_nxt.e.dsh = {39'b0, sq_last.side.a};
		end else begin
			d3_nxt.e.r   = sq_last.side.e_cnum;
			d3_nxt.e.dsh = {23'b0, sq_last.side.e_den};
		end

		d3_nxt.l.q     = '0;
		d3_nxt.l.ovf   = 1'b0;
		d3_nxt.l.never = !sq_last.side.l_root && sq_last.side.vf_zero;
		if (sq_last.side.l_root) begin
			d3_nxt.l.neg = 1'b0;
			d3_nxt.l.r   = {18'b0, {3'b0, sq_last.side.v256} - sq_last.l.root};
			d3_nxt.l.dsh = {39'b0, sq_last.side.a};
		end else begin
			d3_nxt.l.neg = l_neg;
			d3_nxt.l.r   = l_neg ? 45'(-sq_last.side.l_cnum) : sq_last.side.l_cnum[44:0];
			d3_nxt.l.dsh = {23'b0, sq_last.side.l_den};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= sq_vld[SQ_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && sq_vld[SQ_STEPS-1]) begin
			d3_s3 <= d3_nxt;
		end
	end

	// stage 4: overflow check and divisor alignment
	atw_dv_t d4_nxt, d4_s4;

	function automatic atw_dv_lane_t align(input atw_dv_lane_t ln);
		atw_dv_lane_t o;
		o     = ln;
		o.ovf = ({7'b0, ln.r} >= {ln.dsh[27:0], 24'b0});
		o.dsh = {ln.dsh[27:0], 23'b0};
		return o;
	endfunction

	always_comb begin
		d4_nxt.e = align(d3_s3.e);
		d4_nxt.l = align(d3_s3.l);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			d4_s4 <= d4_nxt;
		end
	end

	// divide chain
	for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
		if (j == DV_STEPS - 1) begin : g_last
			assign dv_rdy[j] = !dv_vld[j] || rdy_out;
		end else begin : g_mid
			assign dv_rdy[j] = !dv_vld[j] || dv_rdy[j+1];
		end
		if (j == 0) begin : g_first
			atw_div_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.advance  (dv_rdy[j]),
				.in_valid (vld_s4),
				.in_data  (d4_s4),
				.out_valid(dv_vld[j]),
				.out_data (dv_data[j])
			);
		end else begin : g_next
			atw_div_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.advance  (dv_rdy[j]),
				.in_valid (dv_vld[j-1]),
				.in_data  (dv_data[j-1]),
				.out_valid(dv_vld[j]),
				.out_data (dv_data[j])
			);
		end
	end

	// output: floor toward minus infinity and saturate
	function automatic logic signed [23:0] sat(input atw_dv_lane_t ln);
		logic [24:0] mag;
		logic signed [23:0] t;
		mag = {1'b0, ln.q} + {24'b0, (ln.r != 45'd0)};
		if (ln.never) begin
			t = TIME_MAX;
		end else if (!ln.neg) begin
			t = (ln.ovf || ln.q[23]) ? TIME_MAX : $signed(ln.q);
		end else if (ln.ovf || mag > 25'd8388608) begin
			t = TIME_MIN;
		end else begin
			t = $signed(24'(-mag));
		end
		return t;
	endfunction

	atw_out_t out_q;
	logic     out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rdy_out) begin
			out_vld_q <= dv_vld[DV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && dv_vld[DV_STEPS-1]) begin
			out_q.earliest_arrival <= sat(dv_data[DV_STEPS-1].e);
			out_q.latest_arrival   <= sat(dv_data[DV_STEPS-1].l);
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1 && vld_s2)
		else $error("input stalled with a free front stage");
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s1)
		else $error("accepted request lost at stage 1");
	a_early_pos: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld[0] |-> !dv_data[0].e.neg)
		else $error("earliest quotient marked negative");
	a_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_data.earliest_arrival[23])
		else $error("negative earliest arrival");
`endif

endmodule

// File: bench/arrival_time_window_calc_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arrival_time_window_calc_tb: self-checking bench of the arrival window block
// Drives vehicle requests under random idling and output back-pressure, predicts
// earliest and latest arrival times in 64-bit integer math, and checks in order.
// ----------------------------------------------------------------------------
module arrival_time_window_calc_tb;
	import atw_pkg::*;

	localparam int LATENCY = 56;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	atw_in_t  in_data = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	atw_out_t out_data;
	logic     cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [15:0] cfg_wdata = '0;

	// bench copy of the registers
	longint unsigned cur_top, cur_floor, cur_accel;
	atw_out_t arrivals_due[$];
	int  errors = 0;
	int  results_seen = 0;
	int  requests_sent = 0;
	bit  calm = 1'b0;       // no idling on either side
	int  hold_off = 0;      // forced receiver stall, in cycles

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	arrival_time_window_calc u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint fdiv(longint num, longint den);
		if (num >= 0) return num / den;
		return -((-num + den - 1) / den);
	endfunction

	function automatic logic signed [23:0] clamp_time(longint t);
		if (t > 64'sd8388607) return TIME_MAX;
		if (t < -64'sd8388608) return TIME_MIN;
		return t[23:0];
	endfunction

	// arrival window for one vehicle under the current registers
	function automatic atw_out_t arrival_window(atw_in_t req);
		longint v, d, vm, vf, a, k, v2, te, tl, r, dv;
		atw_out_t res;
		v  = req.speed_now;
		d  = req.distance_left;
		vm = (cur_top == 0) ? 1 : cur_top;
		vf = cur_floor;
		a  = (cur_accel == 0) ? 1 : cur_accel;
		k  = 32 * a * d;
		v2 = v * v;
		if (vm * vm - v2 >= k) begin
			r  = isqrt((v2 + k) << 16);
			te = fdiv(r - v * 256, a);
		end else begin
			dv = vm - v;
			te = fdiv(128 * (k + dv * dv), a * vm);
		end
		if (v2 - vf * vf >= k) begin
			r  = isqrt((v2 - k) << 16);
			tl = fdiv(v * 256 - r, a);
		end else if (vf == 0) begin
			tl = 64'sd8388607;
		end else begin
			dv = v - vf;
			tl = fdiv(128 * (k - dv * dv), a * vf);
		end
		res.earliest_arrival = clamp_time(te);
		res.latest_arrival   = clamp_time(tl);
		return res;
	endfunction

	// receiver: random idling plus forced hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 7);
		end
	end

	// checker
	always @(posedge clk) begin
		atw_out_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (arrivals_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, out_data);
			end else begin
				exp_w = arrivals_due.pop_front();
				if (out_data.earliest_arrival !== exp_w.earliest_arrival) begin
					errors++;
					$display("%0t: earliest expected %0d actual %0d", $time,
						exp_w.earliest_arrival, out_data.earliest_arrival);
				end
				if (out_data.latest_arrival !== exp_w.latest_arrival) begin
					errors++;
					$display("%0t: latest expected %0d actual %0d", $time,
						exp_w.latest_arrival, out_data.latest_arrival);
				end
			end
		end
	end

	// one request; returns at the falling edge after acceptance with valid still high,
	// so back-to-back requests need no gap
	task automatic send_vehicle(logic [15:0] spd, logic [19:0] span);
		atw_in_t req;
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		req.speed_now = spd;
		req.distance_left = span;
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		arrivals_due = {arrivals_due, arrival_window(req)};
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (arrivals_due.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(atw_reg_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TOP_SPEED:   cur_top = val;
			REG_FLOOR_SPEED: cur_floor = val;
			REG_ACCEL_LIMIT: cur_accel = val & 16'h0FFF;
			default: ;
		endcase
	endtask

	task automatic set_limits(logic [15:0] top, logic [15:0] flo, logic [15:0] acc);
		drain_pipe();
		write_reg(REG_TOP_SPEED, top);
		write_reg(REG_FLOOR_SPEED, flo);
		write_reg(REG_ACCEL_LIMIT, acc);
	endtask

	// field extremes, both formula branches, corner registers
	task automatic test_directed();
		send_vehicle(16'd0, 20'd0);
		send_vehicle(16'hFFFF, 20'hFFFFF);
		send_vehicle(16'd0, 20'hFFFFF);
		send_vehicle(16'hFFFF, 20'd0);
		send_vehicle(16'd2560, 20'd16);       // short distance: root cases
		send_vehicle(16'd2560, 20'd16000);    // long distance: cruise cases
		send_vehicle(16'd6000, 20'd800);      // above top speed
		send_vehicle(16'd500, 20'd800);       // below floor speed
		send_vehicle(16'd1792, 20'd1);
		send_vehicle(16'd4096, 20'd5);
		// zero top speed and acceleration act as one, zero floor never arrives
		set_limits(16'd0, 16'd0, 16'd0);
		send_vehicle(16'd300, 20'd50);
		send_vehicle(16'd0, 20'd3);
		send_vehicle(16'hFFFF, 20'hFFFFF);
		send_vehicle(16'd1000, 20'd0);
		set_limits(16'hFFFF, 16'hFFFF, 16'h0FFF);
		send_vehicle(16'hFFFF, 20'hFFFFF);
		send_vehicle(16'd100, 20'd7);
		send_vehicle(16'd0, 20'd0);
		set_limits(16'd1, 16'd0, 16'd1);
		send_vehicle(16'd5, 20'd9);
		send_vehicle(16'hFFFF, 20'h12345);
	endtask

	function automatic logic [19:0] rand_dist();
		case ($urandom_range(3))
			0: return 20'($urandom_range(63));
			1: return 20'($urandom_range(4095));
			2: return 20'($urandom_range(65535));
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_speed();
		if ($urandom_range(3) == 0) return 16'($urandom);
		return 16'($urandom_range(8191));
	endfunction

	task automatic test_random(int n);
		repeat (n) send_vehicle(rand_speed(), rand_dist());
	endtask

	// receiver holds off while the sender keeps offering; pipe fills and stalls
	task automatic test_backpressure();
		calm = 1'b1;
		in_valid <= 1'b0;
		@(negedge clk);
		hold_off = 300;
		test_random(120);
		calm = 1'b0;
		drain_pipe();   // sender waits for every result
	endtask

	initial begin
		cur_top = 4096;
		cur_floor = 1792;
		cur_accel = 256;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		set_limits(16'd4096, 16'd1792, 16'd256);
		test_random(400);
		calm = 1'b1;                  // long stretch without idling
		test_random(300);
		calm = 1'b0;
		test_backpressure();
		set_limits(16'd8000, 16'd200, 16'd40);
		test_random(350);
		set_limits(16'd1000, 16'd3000, 16'd3000);
		test_random(350);
		set_limits(16'($urandom), 16'($urandom), 16'($urandom_range(4095)));
		test_random(300);
		drain_pipe();
		$display("Sent %0d vehicle requests over several register settings, checked %0d results,",
			requests_sent, results_seen);
		$display("including root and cruise branches, corner registers and back-pressure.");
		if (errors == 0 && arrivals_due.size() == 0)
			$display("arrival_time_window_calc verification clean");
		else
			$display("arrival_time_window_calc verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("arrival_time_window_calc verification failed");
		$finish;
	end

endmodule
